// ===== hdl/clms_pkg.sv =====
`default_nettype none
package clms_pkg;

	// matrix geometry
	localparam int LED_COUNT  = 96;
	localparam int PIN_COUNT  = 11;
	localparam int PIN_W      = 4;
	localparam int IDX_W      = 7;
	localparam int LEVEL_W    = 2;
	localparam int TICK_W     = 32;
	localparam int CFG_IDX_W  = 2;

	// level store is addressed by anode * PIN_COUNT + cathode
	localparam int PAIR_COUNT = PIN_COUNT * PIN_COUNT;
	localparam int ADDR_W     = $clog2(PAIR_COUNT);

	localparam int MIN_ON_TICKS = 32;
	localparam int RESET_PERIOD = 4096;
	localparam int RESET_ON     = 4096;

	// command queue depth, a power of two
	localparam int CMDQ_DEPTH = 4;

	// register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD = 2'd0,
		REG_ON     = 2'd1,
		REG_MODE   = 2'd2
	} reg_index_t;

	// anode pin in the high nibble, cathode pin in the low nibble
	localparam logic [7:0] LED_PINS [LED_COUNT] = '{
		8'h73,8'h37,8'h74,8'h47,8'h34,8'h43,8'h78,8'h87,8'h38,8'h83,8'h48,8'h84,
		8'h70,8'h07,8'h30,8'h03,8'h40,8'h04,8'h80,8'h08,8'h76,8'h67,8'h36,8'h63,
		8'h46,8'h64,8'h86,8'h68,8'h06,8'h60,8'h75,8'h57,8'h35,8'h53,8'h45,8'h54,
		8'h85,8'h58,8'h05,8'h50,8'h65,8'h56,8'h71,8'h17,8'h31,8'h13,8'h41,8'h14,
		8'h81,8'h18,8'h01,8'h10,8'h61,8'h16,8'h51,8'h15,8'h72,8'h27,8'h32,8'h23,
		8'h42,8'h24,8'h82,8'h28,8'h02,8'h20,8'h62,8'h26,8'h52,8'h25,8'h12,8'h21,
		8'h7A,8'hA7,8'h3A,8'hA3,8'h4A,8'hA4,8'h8A,8'hA8,8'h0A,8'hA0,8'h6A,8'hA6,
		8'h5A,8'hA5,8'h1A,8'hA1,8'h2A,8'hA2,8'h79,8'h97,8'h39,8'h93,8'h49,8'h94
	};

	typedef struct packed {
		logic               mode;
		logic [IDX_W-1:0]   pix_idx;
		logic [LEVEL_W-1:0] pixel_level;
	} in_item_t;

	typedef struct packed {
		logic [PIN_COUNT-1:0] drive_high_mask;
		logic [PIN_COUNT-1:0] drive_low_mask;
		logic                 reload;
		logic [TICK_W-1:0]    next_period;
	} out_item_t;

	// classified work handed from front to back
	typedef struct packed {
		logic               tick;
		logic [ADDR_W-1:0]  addr;
		logic [LEVEL_W-1:0] level;
	} cmd_t;

	function automatic logic [ADDR_W-1:0] pair_addr(input logic [PIN_W-1:0] anode,
			input logic [PIN_W-1:0] cathode);
		return ADDR_W'(32'(anode) * PIN_COUNT + 32'(cathode));
	endfunction

	function automatic logic [7:0] led_pins(input logic [IDX_W-1:0] idx);
		logic [7:0] pins;
		pins = 8'h00;
		if (32'(idx) < LED_COUNT) begin
			pins = LED_PINS[idx];
		end
		return pins;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/clms_ram.sv =====
`default_nettype none
module clms_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 121
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/clms_front.sv =====
`default_nettype none
module clms_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire clms_pkg::in_item_t item,
	output logic                    cmd_vld,
	output clms_pkg::cmd_t          cmd,
	input  wire logic               cmd_pop
);
	import clms_pkg::*;

	localparam int QA_W = $clog2(CMDQ_DEPTH);

	cmd_t            q_mem_q [CMDQ_DEPTH];
	logic [QA_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QA_W:0]   count_q;
	logic            accept, keep, enq, deq;
	logic [7:0]      in_pins;
	cmd_t            cmd_in;

	// classify: ticks pass, writes map to a pin pair, out-of-range writes drop
	always_comb begin
		in_pins      = led_pins(item.pix_idx);
		cmd_in.tick  = item.mode;
		cmd_in.addr  = pair_addr(in_pins[7:4], in_pins[3:0]);
		cmd_in.level = item.pixel_level;
		keep = item.mode || (32'(item.pix_idx) < LED_COUNT);
	end

	assign full    = (count_q == (QA_W+1)'(CMDQ_DEPTH));
	assign accept  = push && !full;
	assign enq     = accept && keep;
	assign cmd_vld = (count_q != '0);
	assign deq     = cmd_pop && cmd_vld;
	assign cmd     = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (enq) begin
			q_mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				count_q <= count_q + 1'b1;
			end else if (deq && !enq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/clms_back.sv =====
`default_nettype none
module clms_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cmd_vld,
	input  wire clms_pkg::cmd_t                     cmd,
	output logic                                    cmd_pop,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [clms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [clms_pkg::TICK_W-1:0]        cfg_data,
	output logic                                    empty,
	input  wire logic                               pop,
	output clms_pkg::out_item_t                     result
);
	import clms_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_SCAN     = 5'b00010,
		ST_LAST     = 5'b00100,
		ST_ROW_EMIT = 5'b01000,
		ST_PIX_EMIT = 5'b10000
	} state_t;

	state_t state_q;

	// configuration
	logic [TICK_W-1:0] period_q, on_q;
	logic              scan_mode_q;

	// scan state
	logic [PIN_W-1:0]  row_pin_q;
	logic              row_pend_q;
	logic [IDX_W-1:0]  pix_ptr_q;
	logic [TICK_W-1:0] pix_on_q, off_len_q;

	// working registers of one tick
	logic [PIN_W-1:0]     cath_q, rd_cath_q;
	logic                 rd_scan_q, lit_q, rd_vld_q;
	logic [PIN_COUNT-1:0] lo_acc_q;
	logic [TICK_W-1:0]    row_on_q;
	logic [7:0]           pix_led_q;
	logic [PAIR_COUNT-1:0] vld_q;

	logic                 out_vld_q;
	out_item_t            out_q;

	logic                 out_free, tick_go, write_go, off_go, row_start, pix_start;
	logic [ADDR_W-1:0]    raddr;
	logic [LEVEL_W-1:0]   rdata, level;
	logic [7:0]           cur_led;
	logic [TICK_W-1:0]    on_floor, on_clamp, row_off, pix_on, pix_off;
	logic                 pix_set;

	assign cfg_ready = 1'b1;
	assign empty     = !out_vld_q;
	assign result    = out_q;

	// dispatch from the command queue
	always_comb begin
		out_free  = !out_vld_q || pop;
		tick_go   = (state_q == ST_IDLE) && cmd_vld && cmd.tick && out_free;
		write_go  = (state_q == ST_IDLE) && cmd_vld && !cmd.tick;
		cmd_pop   = tick_go || write_go;
		off_go    = tick_go && (scan_mode_q ? (off_len_q != '0) : row_pend_q);
		row_start = tick_go && !scan_mode_q && !row_pend_q;
		pix_start = tick_go && scan_mode_q && (off_len_q == '0);
	end

	// read address: current pixel while idle, row pair while scanning
	always_comb begin
		cur_led = led_pins(pix_ptr_q);
		if (state_q == ST_IDLE) begin
			raddr = pair_addr(cur_led[7:4], cur_led[3:0]);
		end else begin
			raddr = pair_addr(row_pin_q, cath_q);
		end
	end

	clms_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (PAIR_COUNT)
	) u_store (
		.clk   (clk),
		.we    (write_go),
		.waddr (cmd.addr),
		.wdata (cmd.level),
		.raddr (raddr),
		.rdata (rdata)
	);

	// timing arithmetic
	always_comb begin
		level    = rd_vld_q ? rdata : '0;
		on_floor = (on_q < TICK_W'(MIN_ON_TICKS)) ? TICK_W'(MIN_ON_TICKS) : on_q;
		on_clamp = (on_floor > period_q) ? period_q : on_floor;
		row_off  = period_q - row_on_q;
		case (level)
			2'd1:    pix_on = period_q >> 3;
			2'd2:    pix_on = period_q >> 2;
			default: pix_on = period_q;
		endcase
		pix_off = period_q - pix_on;
		pix_set = (pix_on != period_q) || (pix_on_q != period_q);
	end

	// valid bits of the level store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (write_go) begin
			vld_q[cmd.addr] <= 1'b1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		rd_vld_q  <= vld_q[raddr];
		rd_cath_q <= cath_q;
		if (row_start) begin
			cath_q   <= '0;
			row_on_q <= on_clamp;
			lo_acc_q <= '0;
			lit_q    <= 1'b0;
		end else begin
			if (state_q == ST_SCAN) begin
				cath_q <= cath_q + 1'b1;
			end
			if (rd_scan_q && (level != '0)) begin
				lo_acc_q <= lo_acc_q | (PIN_COUNT'(1) << rd_cath_q);
				lit_q    <= 1'b1;
			end
		end
		if (pix_start) begin
			pix_led_q <= cur_led;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (off_go) begin
			out_q <= '{drive_high_mask: '0, drive_low_mask: '0,
				reload: 1'b1, next_period: off_len_q};
		end else if (state_q == ST_ROW_EMIT) begin
			out_q.drive_high_mask <= lit_q ? (PIN_COUNT'(1) << row_pin_q) : '0;
			out_q.drive_low_mask  <= lo_acc_q;
			if (row_on_q != period_q) begin
				out_q.reload      <= 1'b1;
				out_q.next_period <= lit_q ? row_on_q : period_q;
			end else begin
				out_q.reload      <= 1'b0;
				out_q.next_period <= '0;
			end
		end else if (state_q == ST_PIX_EMIT) begin
			out_q.drive_high_mask <= (level != '0) ? (PIN_COUNT'(1) << pix_led_q[7:4]) : '0;
			out_q.drive_low_mask  <= (level != '0) ? (PIN_COUNT'(1) << pix_led_q[3:0]) : '0;
			out_q.reload          <= pix_set;
			out_q.next_period     <= pix_set ? pix_on : '0;
		end
	end

	// control: state machine, scan state, configuration, output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			period_q    <= TICK_W'(RESET_PERIOD);
			on_q        <= TICK_W'(RESET_ON);
			scan_mode_q <= 1'b0;
			row_pin_q   <= '0;
			row_pend_q  <= 1'b0;
			pix_ptr_q   <= '0;
			pix_on_q    <= TICK_W'(RESET_PERIOD);
			off_len_q   <= '0;
			rd_scan_q   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			rd_scan_q <= (state_q == ST_SCAN);

			if (cfg_valid) begin
				case (cfg_index)
					REG_PERIOD: period_q    <= cfg_data;
					REG_ON:     on_q        <= cfg_data;
					REG_MODE:   scan_mode_q <= cfg_data[0];
					default:    ;
				endcase
			end

			// a new beat is loaded as the old one leaves
			if (off_go || (state_q == ST_ROW_EMIT) || (state_q == ST_PIX_EMIT)) begin
				out_vld_q <= 1'b1;
			end else if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (off_go) begin
						row_pend_q <= 1'b0;
						off_len_q  <= '0;
					end else if (row_start) begin
						state_q <= ST_SCAN;
					end else if (pix_start) begin
						state_q <= ST_PIX_EMIT;
					end
				end
				ST_SCAN: begin
					if (cath_q == PIN_W'(PIN_COUNT - 1)) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_ROW_EMIT;
				end
				ST_ROW_EMIT: begin
					if ((row_on_q != period_q) && lit_q) begin
						row_pend_q <= 1'b1;
						off_len_q  <= row_off;
					end
					row_pin_q <= (row_pin_q == PIN_W'(PIN_COUNT - 1)) ? '0 : row_pin_q + 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_PIX_EMIT: begin
					pix_on_q  <= pix_on;
					off_len_q <= pix_off;
					pix_ptr_q <= (pix_ptr_q == IDX_W'(LED_COUNT - 1)) ? '0 : pix_ptr_q + 1'b1;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/charlieplex_led_matrix_scanner.sv =====
// A pixel write passes through the command queue and is written to the level store while the
// sequencer is idle. Ticks are handled one at a time, each once the result register is free;
// the result is registered at dispatch for an off pulse, after the pixel read for a per-pixel
// slot, and after the row scan for a row slot (one read per cathode, 11 pins, one read port).
// Reset (arst_n low) clears the level store's valid bits, so the display starts dark, and
// loads period and on time 4096 with row scan mode; no clearing pass is needed.
`default_nettype none
module charlieplex_led_matrix_scanner (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire clms_pkg::in_item_t             item,
	output logic                                empty,
	input  wire logic                           pop,
	output clms_pkg::out_item_t                 result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [clms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [clms_pkg::TICK_W-1:0]    cfg_data
);
	import clms_pkg::*;

	logic cmd_vld, cmd_pop;
	cmd_t cmd;

	// front: accept and classify beats into the command queue
	clms_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.cmd_vld (cmd_vld),
		.cmd     (cmd),
		.cmd_pop (cmd_pop)
	);

	// back: level store, scan sequencer and result register
	clms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_vld   (cmd_vld),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
`default_nettype wire

// ===== tb/sv/scan_checker.sv =====
`timescale 1ns / 100ps
// Watches the configuration, pixel/tick and drive channels of the scanner,
// keeps its own copy of the scan state and checks every drive beat in order.
module scan_checker
	import clms_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire logic                 full,
	input  wire in_item_t             item,
	input  wire logic                 empty,
	input  wire logic                 pop,
	input  wire out_item_t            result,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TICK_W-1:0]    cfg_data,
	output int                        fail_count,
	output int                        pending_beats
);

	localparam logic OP_TICK = 1'b1;

	localparam logic [LEVEL_W-1:0] LEVEL_OFF     = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_EIGHTH  = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_QUARTER = 2'd2;

	// shadow registers
	logic [TICK_W-1:0] cfg_period;
	logic [TICK_W-1:0] cfg_on;
	logic              cfg_pixel_mode;

	// shadow scan state
	logic [LEVEL_W-1:0] lvl_mem [LED_COUNT];
	logic [PIN_W-1:0]   anode_ptr;
	logic               off_due;
	logic [IDX_W-1:0]   pix_ptr;
	logic [TICK_W-1:0]  pix_on_len;
	logic [TICK_W-1:0]  off_len;

	out_item_t drive_expect [$];
	out_item_t want;
	out_item_t got;

	initial fail_count = 0;
	initial pending_beats = 0;

	task automatic flag(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(input string name, input logic [TICK_W-1:0] seen,
			input logic [TICK_W-1:0] due);
		if (seen !== due) begin
			flag($sformatf("%s got %0h, expected %0h", name, seen, due));
		end
	endtask

	task automatic restore_reset();
		cfg_period     = TICK_W'(RESET_PERIOD);
		cfg_on         = TICK_W'(RESET_ON);
		cfg_pixel_mode = 1'b0;
		for (int i = 0; i < LED_COUNT; i++) begin
			lvl_mem[i] = LEVEL_OFF;
		end
		anode_ptr  = '0;
		off_due    = 1'b0;
		pix_ptr    = '0;
		pix_on_len = TICK_W'(RESET_PERIOD);
		off_len    = '0;
		drive_expect.delete();
	endtask

	// next drive pattern for one timer tick, advancing the scan state
	task automatic predict_drive(output out_item_t r);
		logic [TICK_W-1:0] on_len;
		logic [TICK_W-1:0] off_time;
		logic [IDX_W-1:0]  p;
		logic [7:0]        pins;
		logic              lit;
		r = '0;
		if (!cfg_pixel_mode) begin
			if (off_due) begin
				// dark off pulse after a lit row
				r.reload      = 1'b1;
				r.next_period = off_len;
				off_due = 1'b0;
				off_len = '0;
			end else begin
				if (32'(anode_ptr) >= PIN_COUNT) anode_ptr = '0;
				lit = 1'b0;
				for (int i = 0; i < LED_COUNT; i++) begin
					pins = LED_PINS[i];
					if (pins[7:4] == anode_ptr && lvl_mem[i] != LEVEL_OFF) begin
						lit = 1'b1;
						r.drive_low_mask[pins[3:0]] = 1'b1;
					end
				end
				if (lit) r.drive_high_mask[anode_ptr] = 1'b1;
				// on time raised to the minimum, then capped at the period
				on_len = (cfg_on < TICK_W'(MIN_ON_TICKS)) ? TICK_W'(MIN_ON_TICKS) : cfg_on;
				if (on_len > cfg_period) on_len = cfg_period;
				off_time = cfg_period - on_len;
				if (off_time != '0) begin
					r.reload = 1'b1;
					if (lit) begin
						r.next_period = on_len;
						off_due = 1'b1;
						off_len = off_time;
					end else begin
						r.next_period = cfg_period;
					end
				end
				anode_ptr = (32'(anode_ptr) + 1 >= PIN_COUNT) ? '0 : anode_ptr + 1'b1;
			end
		end else begin
			if (off_len != '0) begin
				// pending off pulse, from either mode
				r.reload      = 1'b1;
				r.next_period = off_len;
				off_len = '0;
				off_due = 1'b0;
			end else begin
				p = (32'(pix_ptr) < LED_COUNT) ? pix_ptr : '0;
				pins = LED_PINS[p];
				if (lvl_mem[p] != LEVEL_OFF) begin
					r.drive_high_mask[pins[7:4]] = 1'b1;
					r.drive_low_mask[pins[3:0]]  = 1'b1;
					case (lvl_mem[p])
						LEVEL_EIGHTH:  on_len = cfg_period >> 3;
						LEVEL_QUARTER: on_len = cfg_period >> 2;
						default:       on_len = cfg_period;
					endcase
				end else begin
					on_len = cfg_period;
				end
				if (on_len != cfg_period || pix_on_len != cfg_period) begin
					r.reload      = 1'b1;
					r.next_period = on_len;
				end
				pix_on_len = on_len;
				off_len    = cfg_period - on_len;
				pix_ptr    = (32'(p) == LED_COUNT - 1) ? '0 : p + 1'b1;
			end
		end
	endtask

	// all three channels are sampled at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restore_reset();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PERIOD: cfg_period = cfg_data;
					REG_ON:     cfg_on = cfg_data;
					REG_MODE:   cfg_pixel_mode = cfg_data[0];
					default:    ;
				endcase
			end
			if (push && !full) begin
				if (item.mode == OP_TICK) begin
					predict_drive(want);
					drive_expect.push_back(want);
				end else if (32'(item.pix_idx) < LED_COUNT) begin
					lvl_mem[item.pix_idx] = item.pixel_level;
				end
			end
			if (pop && !empty) begin
				got = result;
				if (drive_expect.size() == 0) begin
					flag($sformatf("drive beat %0h with none expected", got));
				end else begin
					want = drive_expect.pop_front();
					compare_field("drive_high_mask", 32'(got.drive_high_mask),
						32'(want.drive_high_mask));
					compare_field("drive_low_mask", 32'(got.drive_low_mask),
						32'(want.drive_low_mask));
					compare_field("reload", 32'(got.reload), 32'(want.reload));
					compare_field("next_period", got.next_period, want.next_period);
				end
			end
		end
		pending_beats = drive_expect.size();
	end

endmodule

// ===== tb/sv/charlieplex_led_matrix_scanner_tb.sv =====
`timescale 1ns / 100ps
module charlieplex_led_matrix_scanner_tb;
	import clms_pkg::*;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic SCAN_ROW   = 1'b0;
	localparam logic SCAN_PIXEL = 1'b1;

	localparam logic [TICK_W-1:0] TICKS_MAX = '1;

	// longest row tick plus queued writes, with margin
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES        = 12;
	localparam int PHASE_BEATS   = 152;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	in_item_t             item = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	out_item_t            result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]    cfg_data = '0;

	logic calm = 1'b0;
	int   fail_count;
	int   pending_beats;

	charlieplex_led_matrix_scanner dut (.*);

	scan_checker check (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// drive side stalls with odds of 28 in a hundred unless calm
	always @(negedge clk) begin
		pop <= calm || ($urandom_range(99) >= 28);
	end

	task automatic send_item(input in_item_t beat);
		while (!calm && $urandom_range(99) < 28) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= beat;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	task automatic write_px(input int idx, input int lvl);
		in_item_t beat;
		beat.mode        = OP_WRITE;
		beat.pix_idx     = IDX_W'(idx);
		beat.pixel_level = LEVEL_W'(lvl);
		send_item(beat);
	endtask

	task automatic tick();
		in_item_t beat;
		beat.mode        = OP_TICK;
		beat.pix_idx     = IDX_W'($urandom);
		beat.pixel_level = LEVEL_W'($urandom);
		send_item(beat);
	endtask

	// hold off until every drive beat is back and the block has gone quiet
	task automatic settle();
		push <= 1'b0;
		while (pending_beats != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [TICK_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic apply_config(input logic [TICK_W-1:0] per, input logic [TICK_W-1:0] on_t,
			input logic pix);
		settle();
		write_reg(REG_PERIOD, per);
		write_reg(REG_ON, on_t);
		write_reg(REG_MODE, TICK_W'(pix));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [TICK_W-1:0] random_ticks();
		return $urandom_range(1) ? TICK_W'($urandom) : TICK_W'($urandom_range(2000, 0));
	endfunction

	// mostly ticks and in-range writes, a few writes past the last LED
	function automatic in_item_t random_beat();
		in_item_t beat;
		int roll;
		roll = $urandom_range(99);
		beat.mode = (roll < 50) ? OP_TICK : OP_WRITE;
		beat.pix_idx = (roll >= 95) ? IDX_W'($urandom_range(127, LED_COUNT))
			: IDX_W'($urandom_range(LED_COUNT - 1));
		beat.pixel_level = LEVEL_W'($urandom_range(3));
		return beat;
	endfunction

	initial begin
		logic [TICK_W-1:0] per;
		logic [TICK_W-1:0] on_t;
		logic              pix;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: on time fills the period, writes past the end ignored
		write_px(0, 3);
		write_px(50, 2);
		write_px(127, 3);
		write_px(96, 1);
		tick();
		tick();

		// short on time: lit row, off pulse, dark row, then a pulse left pending
		apply_config(200, 40, SCAN_ROW);
		write_px(57, 1);
		tick();
		tick();
		tick();
		write_px(46, 3);
		tick();

		// per-pixel with a tiny period, taking the row's pending off pulse
		apply_config(4, 0, SCAN_PIXEL);
		write_px(1, 1);
		write_px(2, 2);
		repeat (7) tick();

		// largest period and on time
		apply_config(TICKS_MAX, TICKS_MAX, SCAN_ROW);
		tick();
		tick();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       begin per = 4096;      on_t = 31;        pix = SCAN_ROW;   end
				1:       begin per = 32;        on_t = TICKS_MAX; pix = SCAN_ROW;   end
				2:       begin per = 32;        on_t = 32;        pix = SCAN_PIXEL; end
				3:       begin per = TICKS_MAX; on_t = 32;        pix = SCAN_ROW;   end
				4:       begin per = TICKS_MAX; on_t = random_ticks(); pix = SCAN_PIXEL; end
				5:       begin per = 7;         on_t = 0;         pix = SCAN_PIXEL; end
				6:       begin
					per = $urandom_range(1000, 8);
					on_t = $urandom_range(300);
					pix = SCAN_ROW;
				end
				default: begin
					per = random_ticks();
					on_t = random_ticks();
					pix = 1'($urandom_range(1));
				end
			endcase
			apply_config(per, on_t, pix);
			// one phase with no idling on either side
			calm = (ph == 2);
			repeat (PHASE_BEATS) send_item(random_beat());
		end
		calm = 1'b0;
		settle();

		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/clms_pkg.sv
hdl/clms_ram.sv
hdl/clms_front.sv
hdl/clms_back.sv
hdl/charlieplex_led_matrix_scanner.sv
tb/sv/scan_checker.sv
tb/sv/charlieplex_led_matrix_scanner_tb.sv
